/* src/paf_pkg.sv */
`timescale 1ns / 1ps
// Package for the polyline corner fillet block.
// Holds the default coordinate width, the command codes, the sequencer states and
// the micro-operation codes. It depends on nothing.
package paf_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0,
    CMD_LINE = 2'd1,
    CMD_ARC  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_START,
    ST_MUL,
    ST_SQRT,
    ST_POST,
    ST_DIV,
    ST_QUOT,
    ST_DONE,
    ST_EMIT
  } state_t;

  // Corner work is a fixed sequence of operations on the shared serial units.
  typedef enum logic [3:0] {
    OP_SQ_D0X,
    OP_SQ_D0Y,
    OP_SQ_D1X,
    OP_SQ_D1Y,
    OP_DOT_X,
    OP_DOT_Y,
    OP_CRS_A,
    OP_CRS_B,
    OP_ROOT0,
    OP_ROOT1,
    OP_LEN_PROD,
    OP_ENT_X,
    OP_ENT_Y,
    OP_EXT_X,
    OP_EXT_Y,
    OP_RADIUS
  } op_t;

endpackage

/* src/polyline_arc_fillet.sv */
`timescale 1ns / 1ps
// Polyline corner fillet: turns a stream of vertices into move, line and arc words.
// Depends on paf_pkg for command codes, sequencer states and operation codes.
//
// Usage. Vertices enter on the s_axis channel: tdata carries px then py, tlast marks
// the last vertex of a polyline. Path commands leave on the m_axis channel: tuser is
// the command, tdata carries end_x, end_y, radius and sweep, and tlast marks the last
// word caused by one vertex. A vertex may cause no word, or up to three.
// The block handles one vertex at a time: s_axis_tready is high only while it is idle.
// The first and second vertex of a run need no corner work. An inner corner is
// worked out on a bit-serial multiplier, a digit-by-digit square root and a restoring
// divider, one bit per cycle each, in a fixed sequence of sixteen operations, up to
// five of them divisions.
// Result words are held in a three-entry buffer and offered one per cycle; while the
// receiver stalls the current word holds and no new vertex is taken.
// Reset (rst, synchronous) empties the buffer and starts a new polyline with the
// stored vertices at zero.
module polyline_arc_fillet
  import paf_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_TW  = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((3 * COORD_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TW-1:0]  s_axis_tdata,   // px, py (low to high), zero padded
  input  logic              s_axis_tlast,   // final_vertex
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata,   // end_x, end_y, radius, sweep, zero padded
  output logic [1:0]        m_axis_tuser,   // command
  output logic              m_axis_tlast    // run_end
);

  localparam int W   = COORD_WIDTH;
  localparam int LW  = W + 1;
  localparam int BW  = 2 * W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int SW  = 2 * W + 2;
  localparam int NW  = 3 * W + 2;
  localparam int DVW = 2 * W + 3;
  localparam int RW  = W + 3;
  localparam int CW  = $clog2(NW);
  localparam logic [CW-1:0] MUL_LAST = CW'(W);
  localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);

  state_t state, state_next;
  op_t    op;
  logic [CW-1:0] cnt;
  logic [1:0]    seen_count;

  logic [W-1:0] older_x, older_y, newer_x, newer_y;
  logic [W-1:0] in_x, in_y;
  logic         in_fin;

  logic         d0x_neg, d0y_neg, d1x_neg, d1y_neg;
  logic [W-1:0] d0x_mag, d0y_mag, d1x_mag, d1y_mag;

  logic [BW-1:0] s0, s1;
  logic [PW-1:0] dot, crs;
  logic [LW-1:0] len0, len1;
  logic [PW:0]   den;
  logic [W-1:0]  ent_x, ent_y, ext_x, ext_y, rad;

  logic [BW-1:0] mul_b;
  logic [BW:0]   mul_hi;
  logic [LW-1:0] mul_lo;

  logic [SW-1:0] sq_src;
  logic [LW-1:0] sq_root;
  logic [RW-1:0] sq_rem;

  logic [NW-1:0]  dv_num;
  logic [DVW-1:0] dv_den, dv_rem;
  logic [W-1:0]   dv_q;
  logic           dv_ovf;

  cmd_t         res_cmd [3];
  logic [W-1:0] res_x   [3];
  logic [W-1:0] res_y   [3];
  logic [W-1:0] res_rad [3];
  logic         res_sw  [3];
  logic [1:0]   res_count, res_idx;

  logic [W-1:0] px, py;
  logic         in_take, out_take, out_last;

  assign px       = s_axis_tdata[W-1:0];
  assign py       = s_axis_tdata[2*W-1:W];
  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign out_last = (res_idx == res_count - 2'd1);

  // Sign and magnitude of a - b, which always fits in W bits of magnitude.
  function automatic logic [W:0] diff_sm(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] d;
    logic [W:0] m;
    d = {a[W-1], a} - {b[W-1], b};
    m = d[W] ? (~d + 1'b1) : d;
    return {d[W], m[W-1:0]};
  endfunction

  logic [W:0] sm_d0x, sm_d0y, sm_d1x, sm_d1y;
  assign sm_d0x = diff_sm(older_x, newer_x);
  assign sm_d0y = diff_sm(older_y, newer_y);
  assign sm_d1x = diff_sm(in_x, newer_x);
  assign sm_d1y = diff_sm(in_y, newer_y);

  logic [LW-1:0] len_min;
  logic [PW-1:0] cross_abs;
  logic          den_pos, is_arc;
  assign len_min   = (len0 < len1) ? len0 : len1;
  assign cross_abs = crs[PW-1] ? (~crs + 1'b1) : crs;
  assign den_pos   = !den[PW] && (den != '0);
  assign is_arc    = (len0 != '0) && (len1 != '0) && !((crs == '0) && dot[PW-1]);

  // Operand selection for the serial multiplier and the offset steps.
  logic [LW-1:0] op_a;
  logic [BW-1:0] op_b;
  logic          op_neg;
  logic [W-1:0]  off_base;
  logic          off_neg;
  logic [LW-1:0] off_len;
  logic          op_is_off;

  always_comb begin
    op_a      = '0;
    op_b      = '0;
    op_neg    = 1'b0;
    off_base  = newer_x;
    off_neg   = d0x_neg;
    off_len   = len0;
    op_is_off = 1'b0;
    unique case (op)
      OP_SQ_D0X: begin
        op_a = LW'(d0x_mag); op_b = BW'(d0x_mag);
      end
      OP_SQ_D0Y: begin
        op_a = LW'(d0y_mag); op_b = BW'(d0y_mag);
      end
      OP_SQ_D1X: begin
        op_a = LW'(d1x_mag); op_b = BW'(d1x_mag);
      end
      OP_SQ_D1Y: begin
        op_a = LW'(d1y_mag); op_b = BW'(d1y_mag);
      end
      OP_DOT_X: begin
        op_a = LW'(d0x_mag); op_b = BW'(d1x_mag); op_neg = d0x_neg ^ d1x_neg;
      end
      OP_DOT_Y: begin
        op_a = LW'(d0y_mag); op_b = BW'(d1y_mag); op_neg = d0y_neg ^ d1y_neg;
      end
      OP_CRS_A: begin
        op_a = LW'(d0x_mag); op_b = BW'(d1y_mag); op_neg = d0x_neg ^ d1y_neg;
      end
      OP_CRS_B: begin
        op_a = LW'(d0y_mag); op_b = BW'(d1x_mag); op_neg = d0y_neg ^ d1x_neg;
      end
      OP_ROOT0, OP_ROOT1: begin
        op_a = '0;
      end
      OP_LEN_PROD: begin
        op_a = len0; op_b = BW'(len1);
      end
      OP_ENT_X: begin
        op_a = len_min; op_b = BW'(d0x_mag); op_is_off = 1'b1;
        off_base = newer_x; off_neg = d0x_neg; off_len = len0;
      end
      OP_ENT_Y: begin
        op_a = len_min; op_b = BW'(d0y_mag); op_is_off = 1'b1;
        off_base = newer_y; off_neg = d0y_neg; off_len = len0;
      end
      OP_EXT_X: begin
        op_a = len_min; op_b = BW'(d1x_mag); op_is_off = 1'b1;
        off_base = newer_x; off_neg = d1x_neg; off_len = len1;
      end
      OP_EXT_Y: begin
        op_a = len_min; op_b = BW'(d1y_mag); op_is_off = 1'b1;
        off_base = newer_y; off_neg = d1y_neg; off_len = len1;
      end
      OP_RADIUS: begin
        op_a = len_min; op_b = cross_abs[BW-1:0];
      end
    endcase
  end

  // Shift-and-add multiplier: one multiplier bit per cycle.
  logic [BW:0]          mul_sum;
  logic [BW+LW:0]       prod;
  logic [PW-1:0]        p_signed;
  assign mul_sum  = mul_hi + (mul_lo[0] ? {1'b0, mul_b} : '0);
  assign prod     = {mul_hi, mul_lo};
  assign p_signed = op_neg ? (~prod[PW-1:0] + 1'b1) : prod[PW-1:0];

  // Digit-by-digit square root: two radicand bits per cycle.
  logic [RW+1:0] sq_rem2, sq_trial, sq_diff;
  logic          sq_ge;
  assign sq_rem2  = {sq_rem, sq_src[SW-1:SW-2]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_diff  = sq_rem2 - sq_trial;
  assign sq_ge    = (sq_rem2 >= sq_trial);

  // Restoring divider: one quotient bit per cycle, saturating at W bits.
  logic [DVW:0] dv_rem2, dv_diff;
  logic         dv_ge;
  logic [W-1:0] dv_result, off_val;
  assign dv_rem2   = {dv_rem, dv_num[NW-1]};
  assign dv_diff   = dv_rem2 - {1'b0, dv_den};
  assign dv_ge     = (dv_rem2 >= {1'b0, dv_den});
  assign dv_result = dv_ovf ? '1 : dv_q;
  assign off_val   = off_neg ? (off_base - dv_result) : (off_base + dv_result);

  logic go_div;
  assign go_div = (op_is_off && (off_len != '0)) || ((op == OP_RADIUS) && den_pos);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          unique case (seen_count)
            2'd0:       state_next = ST_EMIT;
            2'd1:       state_next = s_axis_tlast ? ST_EMIT : ST_IDLE;
            2'd2, 2'd3: state_next = ST_DIFF;
          endcase
        end
      end
      ST_DIFF:  state_next = ST_START;
      ST_START: state_next = ((op == OP_ROOT0) || (op == OP_ROOT1)) ? ST_SQRT : ST_MUL;
      ST_MUL:   if (cnt == MUL_LAST) state_next = ST_POST;
      ST_SQRT:  if (cnt == MUL_LAST) state_next = ST_POST;
      ST_POST: begin
        if (go_div)                 state_next = ST_DIV;
        else if (op == OP_RADIUS)   state_next = ST_DONE;
        else                        state_next = ST_START;
      end
      ST_DIV:   if (cnt == DIV_LAST) state_next = ST_QUOT;
      ST_QUOT:  state_next = (op == OP_RADIUS) ? ST_DONE : ST_START;
      ST_DONE:  state_next = ST_EMIT;
      ST_EMIT:  if (out_take && out_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_EMIT);
    m_axis_tuser  = res_cmd[res_idx];
    m_axis_tlast  = out_last;
    m_axis_tdata  = OUT_TW'({res_sw[res_idx], res_rad[res_idx], res_y[res_idx],
                             res_x[res_idx]});
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op         <= OP_SQ_D0X;
      cnt        <= '0;
      seen_count <= 2'd0;
      res_count  <= 2'd0;
      res_idx    <= 2'd0;
      older_x    <= '0;
      older_y    <= '0;
      newer_x    <= '0;
      newer_y    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            res_idx <= 2'd0;
            unique case (seen_count)
              2'd0: begin
                res_count  <= s_axis_tlast ? 2'd2 : 2'd1;
                seen_count <= s_axis_tlast ? 2'd0 : 2'd1;
                older_x <= newer_x; older_y <= newer_y;
                newer_x <= px;      newer_y <= py;
              end
              2'd1: begin
                res_count  <= s_axis_tlast ? 2'd1 : 2'd0;
                seen_count <= s_axis_tlast ? 2'd0 : 2'd2;
                older_x <= newer_x; older_y <= newer_y;
                newer_x <= px;      newer_y <= py;
              end
              2'd2, 2'd3: begin
              end
            endcase
          end
        end
        ST_DIFF:  op <= OP_SQ_D0X;
        ST_START: cnt <= '0;
        ST_MUL, ST_SQRT, ST_DIV: cnt <= cnt + 1'b1;
        ST_POST: begin
          cnt <= '0;
          if (!go_div && (op != OP_RADIUS)) op <= op_t'(op + 4'd1);
        end
        ST_QUOT: if (op != OP_RADIUS) op <= op_t'(op + 4'd1);
        ST_DONE: begin
          res_idx    <= 2'd0;
          res_count  <= in_fin ? 2'd3 : 2'd2;
          seen_count <= in_fin ? 2'd0 : 2'd2;
          older_x <= newer_x; older_y <= newer_y;
          newer_x <= in_x;    newer_y <= in_y;
        end
        ST_EMIT: if (out_take && !out_last) res_idx <= res_idx + 2'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          in_x   <= px;
          in_y   <= py;
          in_fin <= s_axis_tlast;
          if (seen_count == 2'd0) begin
            res_cmd[0] <= CMD_MOVE; res_x[0] <= px; res_y[0] <= py;
            res_rad[0] <= '0;       res_sw[0] <= 1'b0;
            res_cmd[1] <= CMD_LINE; res_x[1] <= px; res_y[1] <= py;
            res_rad[1] <= '0;       res_sw[1] <= 1'b0;
          end else begin
            res_cmd[0] <= CMD_LINE; res_x[0] <= px; res_y[0] <= py;
            res_rad[0] <= '0;       res_sw[0] <= 1'b0;
          end
        end
      end
      ST_DIFF: begin
        {d0x_neg, d0x_mag} <= sm_d0x;
        {d0y_neg, d0y_mag} <= sm_d0y;
        {d1x_neg, d1x_mag} <= sm_d1x;
        {d1y_neg, d1y_mag} <= sm_d1y;
      end
      ST_START: begin
        mul_b   <= op_b;
        mul_hi  <= '0;
        mul_lo  <= op_a;
        sq_src  <= (op == OP_ROOT0) ? {1'b0, s0} : {1'b0, s1};
        sq_root <= '0;
        sq_rem  <= '0;
      end
      ST_MUL: begin
        mul_hi <= {1'b0, mul_sum[BW:1]};
        mul_lo <= {mul_sum[0], mul_lo[LW-1:1]};
      end
      ST_SQRT: begin
        sq_src  <= {sq_src[SW-3:0], 2'b00};
        sq_rem  <= sq_ge ? sq_diff[RW-1:0] : sq_rem2[RW-1:0];
        sq_root <= {sq_root[LW-2:0], sq_ge};
      end
      ST_POST: begin
        dv_rem <= '0;
        dv_q   <= '0;
        dv_ovf <= 1'b0;
        unique case (op)
          OP_SQ_D0X:   s0 <= prod[BW-1:0];
          OP_SQ_D0Y:   s0 <= s0 + prod[BW-1:0];
          OP_SQ_D1X:   s1 <= prod[BW-1:0];
          OP_SQ_D1Y:   s1 <= s1 + prod[BW-1:0];
          OP_DOT_X:    dot <= p_signed;
          OP_DOT_Y:    dot <= dot + p_signed;
          OP_CRS_A:    crs <= p_signed;
          OP_CRS_B:    crs <= crs - p_signed;
          OP_ROOT0:    len0 <= sq_root;
          OP_ROOT1:    len1 <= sq_root;
          OP_LEN_PROD: den <= {1'b0, prod[PW-1:0]} + {dot[PW-1], dot};
          OP_ENT_X, OP_ENT_Y, OP_EXT_X, OP_EXT_Y: begin
            // Rounded half offset: (|d|*l + len) / (2*len).
            dv_num <= prod[NW-1:0] + NW'(off_len);
            dv_den <= DVW'({off_len, 1'b0});
            if (off_len == '0) begin
              unique case (op)
                OP_ENT_X: ent_x <= off_base;
                OP_ENT_Y: ent_y <= off_base;
                OP_EXT_X: ext_x <= off_base;
                default:  ext_y <= off_base;
              endcase
            end
          end
          OP_RADIUS: begin
            dv_num <= prod[NW-1:0];
            dv_den <= {den[PW-1:0], 1'b0};
            if (!den_pos) rad <= '1;
          end
        endcase
      end
      ST_DIV: begin
        dv_num <= {dv_num[NW-2:0], 1'b0};
        dv_rem <= dv_ge ? dv_diff[DVW-1:0] : dv_rem2[DVW-1:0];
        dv_q   <= {dv_q[W-2:0], dv_ge};
        dv_ovf <= dv_ovf | dv_q[W-1];
      end
      ST_QUOT: begin
        unique case (op)
          OP_ENT_X: ent_x <= off_val;
          OP_ENT_Y: ent_y <= off_val;
          OP_EXT_X: ext_x <= off_val;
          OP_EXT_Y: ext_y <= off_val;
          default:  rad   <= dv_result;
        endcase
      end
      ST_DONE: begin
        res_cmd[0] <= CMD_LINE; res_x[0] <= ent_x; res_y[0] <= ent_y;
        res_rad[0] <= '0;       res_sw[0] <= 1'b0;
        res_cmd[1] <= is_arc ? CMD_ARC : CMD_LINE;
        res_x[1]   <= ext_x;
        res_y[1]   <= ext_y;
        res_rad[1] <= is_arc ? rad : '0;
        res_sw[1]  <= is_arc && crs[PW-1];
        res_cmd[2] <= CMD_LINE; res_x[2] <= in_x; res_y[2] <= in_y;
        res_rad[2] <= '0;       res_sw[2] <= 1'b0;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // Only one side of the block is ever open at a time.
  assert property (@(posedge clk) disable iff (rst) !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open together");

  // The word on offer always lies inside the filled part of the buffer.
  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> (res_idx < res_count))
    else $error("result index beyond buffer fill");

  // Once the last word of a vertex is taken the block is ready for the next vertex.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block not idle after last word");

  // A corner always finishes with the radius operation before its words are offered.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (op == OP_RADIUS))
    else $error("corner finished early");
`endif

endmodule
